// ===== rtl/qac_pkg.sv =====
// Shared constants and types of the quad area centroid pipeline.
// No dependencies; used by qac_div and quad_area_centroid_core.
`default_nettype none

package qac_pkg;

  // default coordinate width, two's complement
  localparam int unsigned COORD_BITS = 24;
  // operand slice width of the wide multipliers
  localparam int unsigned MUL_CHUNK  = 32;

  // divider status that travels with the quotient
  typedef struct packed {
    logic sat;  // quotient does not fit the coordinate range
    logic neg;  // numerator was negative
  } div_flags_t;

endpackage

`default_nettype wire

// ===== rtl/qac_delay.sv =====
// Enabled register chain that carries side data alongside the pipeline.
// No dependencies.
`default_nettype none

module qac_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] stage_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        stage_q[i] <= stage_q[i-1];
      end
    end
  end

  assign q_o = stage_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/qac_mul.sv =====
// Two-stage signed multiplier: registered slice products, then a registered sum.
// No dependencies.
`default_nettype none

module qac_mul #(
  parameter int unsigned WA    = 8,
  parameter int unsigned WB    = 8,
  parameter int unsigned CHUNK = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [WA-1:0]  a_i,
  input  wire logic signed [WB-1:0]  b_i,
  output logic signed [WA+WB-1:0]    p_o
);

  localparam int unsigned NA   = (WA + CHUNK - 1) / CHUNK;
  localparam int unsigned NB   = (WB + CHUNK - 1) / CHUNK;
  localparam int unsigned EA   = NA * CHUNK;
  localparam int unsigned EB   = NB * CHUNK;
  localparam int unsigned PPW  = 2 * CHUNK + 2;
  localparam int unsigned SUMW = EA + EB;

  logic signed [EA-1:0]    a_ext;
  logic signed [EB-1:0]    b_ext;
  logic signed [CHUNK:0]   ca [NA];
  logic signed [CHUNK:0]   cb [NB];
  logic signed [PPW-1:0]   pp_q [NA][NB];
  logic signed [SUMW-1:0]  sum;
  logic signed [WA+WB-1:0] p_q;

  assign a_ext = EA'(a_i);
  assign b_ext = EB'(b_i);

  // low slices are unsigned, the top slice carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_sa
    if (i == NA - 1) begin : g_top
      assign ca[i] = $signed({a_ext[i*CHUNK+CHUNK-1], a_ext[i*CHUNK +: CHUNK]});
    end else begin : g_low
      assign ca[i] = $signed({1'b0, a_ext[i*CHUNK +: CHUNK]});
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_sb
    if (j == NB - 1) begin : g_top
      assign cb[j] = $signed({b_ext[j*CHUNK+CHUNK-1], b_ext[j*CHUNK +: CHUNK]});
    end else begin : g_low
      assign cb[j] = $signed({1'b0, b_ext[j*CHUNK +: CHUNK]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ca[i] * cb[j];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SUMW'(pp_q[i][j]) <<< ((i + j) * CHUNK));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum[WA+WB-1:0];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/qac_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounding to nearest.
// Depends on qac_pkg for the status struct.
`default_nettype none

module qac_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16,
  parameter int unsigned Q_W   = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output logic             [Q_W-1:0]   q_o,
  output qac_pkg::div_flags_t          flags_o
);

  localparam int unsigned YW  = DEN_W + 1;
  localparam int unsigned RW0 = (NUM_W + 1 > YW + Q_W) ? NUM_W + 1 : YW + Q_W;
  localparam int unsigned RW  = RW0 + 1;

  logic [NUM_W-1:0] mag;
  logic [RW-1:0]    xa_q;
  logic [YW-1:0]    ya_q;
  logic             na_q;

  logic [RW-1:0]       r_q    [Q_W+1];
  logic [YW-1:0]       y_q    [Q_W+1];
  logic [Q_W-1:0]      q_q    [Q_W+1];
  qac_pkg::div_flags_t flg_q  [Q_W+1];

  assign mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  // round half away: (2|n| + d) / 2d
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= (RW'(mag) << 1) + RW'(den_i);
      ya_q <= {den_i, 1'b0};
      na_q <= num_i[NUM_W-1];
    end
  end

  // overflow check: the quotient would need a bit above its top weight
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]       <= xa_q;
      y_q[0]       <= ya_q;
      q_q[0]       <= '0;
      flg_q[0].sat <= xa_q >= (RW'(ya_q) << Q_W);
      flg_q[0].neg <= na_q;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int unsigned SH = Q_W - 1 - s;
    logic [RW-1:0] ys;
    logic          ge;

    assign ys = RW'(y_q[s]) << SH;
    assign ge = r_q[s] >= ys;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]   <= ge ? r_q[s] - ys : r_q[s];
        y_q[s+1]   <= y_q[s];
        q_q[s+1]   <= {q_q[s][Q_W-2:0], ge};
        flg_q[s+1] <= flg_q[s];
      end
    end
  end

  assign q_o     = q_q[Q_W];
  assign flags_o = flg_q[Q_W];

endmodule

`default_nettype wire

// ===== rtl/quad_area_centroid_core.sv =====
// Area centroid of a quadrilateral: pipeline of cross products, dot products,
// wide multiplies and a bit-per-stage divider. One word in and one word out per
// clock; the whole pipeline holds while a finished word waits at the output.
// Most of the pipeline depth lies in the divider, which resolves one quotient
// bit per stage. When the centroid lines are parallel the word carries
// degenerate = 1 and zero coordinates; other results are rounded to nearest
// (ties away from zero) and saturated to the coordinate range.
// Depends on qac_pkg, qac_delay, qac_mul and qac_div.
`default_nettype none

module quad_area_centroid_core #(
  parameter int unsigned COORD_BITS = qac_pkg::COORD_BITS,
  parameter int unsigned MUL_CHUNK  = qac_pkg::MUL_CHUNK
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] p0_x_i,
  input  wire logic signed [COORD_BITS-1:0] p0_y_i,
  input  wire logic signed [COORD_BITS-1:0] p0_z_i,
  input  wire logic signed [COORD_BITS-1:0] p1_x_i,
  input  wire logic signed [COORD_BITS-1:0] p1_y_i,
  input  wire logic signed [COORD_BITS-1:0] p1_z_i,
  input  wire logic signed [COORD_BITS-1:0] p2_x_i,
  input  wire logic signed [COORD_BITS-1:0] p2_y_i,
  input  wire logic signed [COORD_BITS-1:0] p2_z_i,
  input  wire logic signed [COORD_BITS-1:0] p3_x_i,
  input  wire logic signed [COORD_BITS-1:0] p3_y_i,
  input  wire logic signed [COORD_BITS-1:0] p3_z_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0]      center_x_o,
  output logic signed [COORD_BITS-1:0]      center_y_o,
  output logic signed [COORD_BITS-1:0]      center_z_o,
  output logic                              degenerate_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned VW  = CW + 1;       // edge vectors
  localparam int unsigned SW  = CW + 2;       // vertex sum
  localparam int unsigned PW  = 2 * VW;       // cross product terms
  localparam int unsigned XW  = PW + 1;       // cross product components
  localparam int unsigned SQW = 2 * XW;
  localparam int unsigned DW  = SQW + 2;      // D and N
  localparam int unsigned SDW = SW + DW;
  localparam int unsigned ANW = VW + DW;
  localparam int unsigned MW  = SDW + 1;      // numerator
  localparam int unsigned D3W = DW + 2;       // 3*D
  localparam int unsigned QB  = CW - 1;
  localparam int unsigned L   = QB + 12;

  logic         en;
  logic [L-1:0] vld_q;

  logic signed [CW-1:0] pin [4][3];

  logic signed [VW-1:0]  a_q [3];
  logic signed [VW-1:0]  b_q [3];
  logic signed [VW-1:0]  c_q [3];
  logic signed [SW-1:0]  s_q [3];
  logic signed [PW-1:0]  ab1_q [3];
  logic signed [PW-1:0]  ab2_q [3];
  logic signed [PW-1:0]  cb1_q [3];
  logic signed [PW-1:0]  cb2_q [3];
  logic signed [XW-1:0]  axb_q [3];
  logic signed [XW-1:0]  cxb_q [3];
  logic signed [SQW-1:0] sq [3];
  logic signed [SQW-1:0] cx [3];
  logic signed [DW-1:0]  d_q;
  logic signed [DW-1:0]  n_q;
  logic [VW+SW-1:0]      as_dly [3];
  logic signed [SDW-1:0] sd [3];
  logic signed [ANW-1:0] an [3];
  logic [DW-1:0]         d_dly;
  logic signed [MW-1:0]  num_q [3];
  logic [D3W-1:0]        den3_q;
  logic                  deg_dly;
  logic [QB-1:0]         quo [3];
  qac_pkg::div_flags_t   flg [3];
  logic signed [CW-1:0]  res_d [3];
  logic signed [CW-1:0]  res_q [3];
  logic                  deg_q;

  // whole pipeline advances unless a finished word is held
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  assign pin[0][0] = p0_x_i;
  assign pin[0][1] = p0_y_i;
  assign pin[0][2] = p0_z_i;
  assign pin[1][0] = p1_x_i;
  assign pin[1][1] = p1_y_i;
  assign pin[1][2] = p1_z_i;
  assign pin[2][0] = p2_x_i;
  assign pin[2][1] = p2_y_i;
  assign pin[2][2] = p2_z_i;
  assign pin[3][0] = p3_x_i;
  assign pin[3][1] = p3_y_i;
  assign pin[3][2] = p3_z_i;

  // scaled by 3: A = p2-p0, B = p3-p1, C = p2-p3, S = p0+p1+p3
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= VW'(pin[2][k]) - VW'(pin[0][k]);
        b_q[k] <= VW'(pin[3][k]) - VW'(pin[1][k]);
        c_q[k] <= VW'(pin[2][k]) - VW'(pin[3][k]);
        s_q[k] <= SW'(pin[0][k]) + SW'(pin[1][k]) + SW'(pin[3][k]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int unsigned K1 = (k + 1) % 3;
    localparam int unsigned K2 = (k + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en) begin
        ab1_q[k] <= a_q[K1] * b_q[K2];
        ab2_q[k] <= a_q[K2] * b_q[K1];
        cb1_q[k] <= c_q[K1] * b_q[K2];
        cb2_q[k] <= c_q[K2] * b_q[K1];
        axb_q[k] <= XW'(ab1_q[k]) - XW'(ab2_q[k]);
        cxb_q[k] <= XW'(cb1_q[k]) - XW'(cb2_q[k]);
      end
    end

    qac_mul #(.WA(XW), .WB(XW), .CHUNK(MUL_CHUNK)) u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (axb_q[k]),
      .b_i   (axb_q[k]),
      .p_o   (sq[k])
    );

    qac_mul #(.WA(XW), .WB(XW), .CHUNK(MUL_CHUNK)) u_cx (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (cxb_q[k]),
      .b_i   (axb_q[k]),
      .p_o   (cx[k])
    );

    qac_delay #(.W(VW + SW), .N(5)) u_as_dly (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   ({a_q[k], s_q[k]}),
      .q_o   (as_dly[k])
    );

    qac_mul #(.WA(SW), .WB(DW), .CHUNK(MUL_CHUNK)) u_sd (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(as_dly[k][SW-1:0])),
      .b_i   (d_q),
      .p_o   (sd[k])
    );

    qac_mul #(.WA(VW), .WB(DW), .CHUNK(MUL_CHUNK)) u_an (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(as_dly[k][VW+SW-1:SW])),
      .b_i   (n_q),
      .p_o   (an[k])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[k] <= MW'(sd[k]) + MW'(an[k]);
      end
    end

    qac_div #(.NUM_W(MW), .DEN_W(D3W), .Q_W(QB)) u_div (
      .clk_i   (clk_i),
      .en_i    (en),
      .num_i   (num_q[k]),
      .den_i   (den3_q),
      .q_o     (quo[k]),
      .flags_o (flg[k])
    );

    always_comb begin
      if (deg_dly) begin
        res_d[k] = '0;
      end else if (flg[k].sat) begin
        res_d[k] = flg[k].neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else if (flg[k].neg) begin
        res_d[k] = ~{1'b0, quo[k]} + 1'b1;
      end else begin
        res_d[k] = {1'b0, quo[k]};
      end
    end
  end

  // D = |AxB|^2, N = (CxB).(AxB)
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]);
      n_q <= DW'(cx[0]) + DW'(cx[1]) + DW'(cx[2]);
    end
  end

  qac_delay #(.W(DW), .N(2)) u_d_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (d_q),
    .q_o   (d_dly)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      den3_q <= D3W'(d_dly) + (D3W'(d_dly) << 1);
    end
  end

  qac_delay #(.W(1), .N(QB + 5)) u_deg_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (d_q == '0),
    .q_o   (deg_dly)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      res_q[2] <= res_d[2];
      deg_q    <= deg_dly;
    end
  end

  assign center_x_o   = res_q[0];
  assign center_y_o   = res_q[1];
  assign center_z_o   = res_q[2];
  assign degenerate_o = deg_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      center_x_o == '0 && center_y_o == '0 && center_z_o == '0)
    else $error("degenerate word carries nonzero center");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved while pipeline held");

  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !vld_q[L-2] |=> !out_valid_o)
    else $error("output word appeared from an empty stage");

  a_accept_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted word lost at pipeline entry");

endmodule

`default_nettype wire
